### sv/bnic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnic_pkg: shared types, constants and microcode for the batch-norm channel
// Widths of the fixed-point datapath, the sequencer step codes, the datapath
// operation codes and the control-store contents.
// ----------------------------------------------------------------------------
package bnic_pkg;

    // Field widths of the stream words.
    localparam int VAL_W    = 32;               // Q16.16 values
    localparam int FRAC_W   = 16;               // fraction bits
    localparam int VAR_W    = 31;               // variance field
    localparam int EPS_W    = 17;               // epsilon register
    localparam int STATUS_W = 2;

    // Stream packing: sample, gamma, beta, mean, variance, one pad bit.
    localparam int S_TDATA_W = ((4 * VAL_W + VAR_W + 7) / 8) * 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = VAL_W;
    localparam int M_TUSER_W = STATUS_W;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

    // Register index of epsilon in the configuration map.
    localparam logic REG_EPSILON = 1'b0;

    // Inverse square root: inv = floor(sqrt(floor(2^48 / V))).
    localparam int V_W        = VAR_W + 1;              // variance + epsilon
    localparam int DIV_STEPS  = 3 * FRAC_W + 1;         // quotient bits
    localparam int LQ_W       = DIV_STEPS + 1;          // even, for 2-bit digits
    localparam int SQRT_STEPS = LQ_W / 2;
    localparam int INV_W      = SQRT_STEPS;
    localparam int CNT_W      = 6;
    localparam int DIV_LAST   = DIV_STEPS - 1;
    localparam int SQRT_LAST  = SQRT_STEPS - 1;

    // Shared multiplier and element arithmetic.
    localparam int D_W      = VAL_W + 1;                // x - mean
    localparam int MUL_A_W  = VAL_W + 2;
    localparam int MUL_B_W  = INV_W + 1;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int T_W      = D_W + INV_W - FRAC_W;     // floor(d*inv/2^16)
    localparam int T_LO_W   = (T_W + 1) / 2;
    localparam int T_HI_W   = T_W - T_LO_W;
    localparam int ACC_W    = T_W + VAL_W;              // t * gamma
    localparam int YW_W     = ACC_W - FRAC_W + 1;       // plus beta

    // Cycle count from a header's acceptance to its final step.
    localparam int HDR_FIN_LAT = DIV_STEPS + SQRT_STEPS + 3;

    typedef enum logic [0:0] {
        KIND_HDR  = 1'b0,
        KIND_DATA = 1'b1
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_SAT     = 2'd1,
        ST_NOPARAM = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_SET_LOADED,
        OP_MUL_D_INV,
        OP_MUL_T_LO,
        OP_MUL_T_HI,
        OP_ADD_HI,
        OP_EMIT_Y,
        OP_EMIT_NOPARAM
    } t_op;

    typedef enum logic [1:0] {
        BR_NEXT,
        BR_LOOP,
        BR_END
    } t_br;

    typedef enum logic [3:0] {
        S_IDLE,
        S_H_INIT,
        S_H_DIV,
        S_H_SQI,
        S_H_SQ,
        S_H_FIN,
        S_D_MUL0,
        S_D_MUL1,
        S_D_MUL2,
        S_D_ADD,
        S_D_OUT,
        S_D_NOP
    } t_step;

    typedef struct packed {
        t_op              op;
        t_br              br;
        logic             cnt_load;
        logic [CNT_W-1:0] cnt_init;
        logic             wait_out;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic hdr_load;
        logic dat_load;
    } t_dp_ctrl;

    // Control store: one word per step.
    function automatic t_uword ucode_rom(t_step pc);
        t_uword uw;
        uw = '{op: OP_NOP, br: BR_END, cnt_load: 1'b0, cnt_init: '0, wait_out: 1'b0};
        unique case (pc)
            S_IDLE: begin
                uw.op = OP_NOP;
            end
            S_H_INIT: begin
                uw.op       = OP_DIV_INIT;
                uw.br       = BR_NEXT;
                uw.cnt_load = 1'b1;
                uw.cnt_init = CNT_W'(DIV_LAST);
            end
            S_H_DIV: begin
                uw.op = OP_DIV_STEP;
                uw.br = BR_LOOP;
            end
            S_H_SQI: begin
                uw.op       = OP_SQRT_INIT;
                uw.br       = BR_NEXT;
                uw.cnt_load = 1'b1;
                uw.cnt_init = CNT_W'(SQRT_LAST);
            end
            S_H_SQ: begin
                uw.op = OP_SQRT_STEP;
                uw.br = BR_LOOP;
            end
            S_H_FIN: begin
                uw.op = OP_SET_LOADED;
                uw.br = BR_END;
            end
            S_D_MUL0: begin
                uw.op = OP_MUL_D_INV;
                uw.br = BR_NEXT;
            end
            S_D_MUL1: begin
                uw.op = OP_MUL_T_LO;
                uw.br = BR_NEXT;
            end
            S_D_MUL2: begin
                uw.op = OP_MUL_T_HI;
                uw.br = BR_NEXT;
            end
            S_D_ADD: begin
                uw.op = OP_ADD_HI;
                uw.br = BR_NEXT;
            end
            S_D_OUT: begin
                uw.op       = OP_EMIT_Y;
                uw.br       = BR_END;
                uw.wait_out = 1'b1;
            end
            S_D_NOP: begin
                uw.op       = OP_EMIT_NOPARAM;
                uw.br       = BR_END;
                uw.wait_out = 1'b1;
            end
            default: begin
                uw.op = OP_NOP;
            end
        endcase
        return uw;
    endfunction

endpackage

### sv/batchnorm_inference_channel.sv
`timescale 1ns / 1ps
// A data word is taken, and its result is registered on the master side after four steps
// through the one shared multiplier and adder; the next word is taken once it is emitted.
// A data word that arrives before any header gives its error result from its output step alone.
// A header runs a 49-step restoring divider and a 25-step square root before the next word is taken.
// A result waiting on the master side does not block the next input word.
// Reset (synchronous, active low) clears the sequencer, the output and the loaded flag; epsilon = 1.
// ----------------------------------------------------------------------------
// batchnorm_inference_channel: batch normalization for inference, per channel
// Header words load gamma, beta and mean and compute the inverse standard
// deviation; data words are normalized in Q16.16 by a microcoded sequencer.
// ----------------------------------------------------------------------------
module batchnorm_inference_channel (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Slave stream.
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // tdata: sample[31:0], scale_gamma[63:32], shift_beta[95:64],
    //        running_mean[127:96], running_variance[158:128], zero[159]
    input  logic [bnic_pkg::S_TDATA_W-1:0]      i_s_tdata,
    // tuser: kind[0]
    input  logic [bnic_pkg::S_TUSER_W-1:0]      i_s_tuser,
    // Master stream.
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // tdata: normalized[31:0]
    output logic [bnic_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // tuser: status[1:0]
    output logic [bnic_pkg::M_TUSER_W-1:0]      o_m_tuser,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bnic_pkg::APB_AW-1:0]         paddr,
    input  logic [bnic_pkg::APB_DW-1:0]         pwdata,
    output logic [bnic_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);
    import bnic_pkg::*;

    t_step                 r_pc, n_pc;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [EPS_W-1:0]      r_eps, n_eps;
    logic                  r_loaded, n_loaded;
    logic                  r_out_valid, n_out_valid;
    logic [VAL_W-1:0]      r_out_data, n_out_data;
    t_status               r_out_status, n_out_status;

    t_uword                uw;
    t_dp_ctrl              dp_ctrl;
    t_kind                 in_kind;
    logic                  s_acc;
    logic                  stall;
    logic                  emit_go;
    logic                  cfg_wr;
    logic signed [VAL_W-1:0] dp_y;
    logic                  dp_sat;

    // ------------------------------------------------------------------
    // Configuration: a single epsilon register at byte address 0.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        n_eps = r_eps;
        if (cfg_wr && (paddr[2] == REG_EPSILON)) begin
            n_eps = pwdata[EPS_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_EPSILON) ? APB_DW'(r_eps) : '0;

    // ------------------------------------------------------------------
    // Sequencer. The control word of the current step drives the datapath.
    // Only the output steps can stall, when the previous result has not
    // been taken yet.
    // ------------------------------------------------------------------
    assign in_kind    = t_kind'(i_s_tuser[0]);
    assign o_s_tready = (r_pc == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;

    assign uw      = ucode_rom(r_pc);
    assign stall   = uw.wait_out && r_out_valid && !i_m_tready;
    assign emit_go = ((uw.op == OP_EMIT_Y) || (uw.op == OP_EMIT_NOPARAM)) && !stall;

    // Next step.
    always_comb begin
        n_pc = r_pc;
        priority if (r_pc == S_IDLE) begin
            if (s_acc) begin
                priority if (in_kind == KIND_HDR) begin
                    n_pc = S_H_INIT;
                end else if (r_loaded) begin
                    n_pc = S_D_MUL0;
                end else begin
                    n_pc = S_D_NOP;
                end
            end
        end else if (stall) begin
            n_pc = r_pc;
        end else begin
            unique case (uw.br)
                BR_NEXT: n_pc = t_step'(r_pc + 4'd1);
                BR_LOOP: n_pc = (r_cnt != '0) ? r_pc : t_step'(r_pc + 4'd1);
                BR_END:  n_pc = S_IDLE;
                default: n_pc = S_IDLE;
            endcase
        end
    end

    // Step outputs: loop counter, datapath control, loaded flag.
    always_comb begin
        n_cnt    = r_cnt;
        n_loaded = r_loaded;
        dp_ctrl.op       = stall ? OP_NOP : uw.op;
        dp_ctrl.hdr_load = s_acc && (in_kind == KIND_HDR);
        dp_ctrl.dat_load = s_acc && (in_kind == KIND_DATA);
        if (!stall) begin
            if (uw.cnt_load) begin
                n_cnt = uw.cnt_init;
            end else if ((uw.br == BR_LOOP) && (r_cnt != '0)) begin
                n_cnt = r_cnt - CNT_W'(1);
            end
        end
        if (uw.op == OP_SET_LOADED) begin
            n_loaded = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds one result until the master side takes it.
    // ------------------------------------------------------------------
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        if (emit_go) begin
            n_out_valid = 1'b1;
            if (uw.op == OP_EMIT_Y) begin
                n_out_data   = dp_y;
                n_out_status = dp_sat ? ST_SAT : ST_OK;
            end else begin
                n_out_data   = '0;
                n_out_status = ST_NOPARAM;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= S_IDLE;
            r_cnt       <= '0;
            r_eps       <= EPS_RESET;
            r_loaded    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_cnt       <= n_cnt;
            r_eps       <= n_eps;
            r_loaded    <= n_loaded;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
    end

    // ------------------------------------------------------------------
    // Datapath.
    // ------------------------------------------------------------------
    bnic_datapath u_datapath (
        .i_clk      (i_clk),
        .i_ctrl     (dp_ctrl),
        .i_sample   ($signed(i_s_tdata[VAL_W-1:0])),
        .i_gamma    ($signed(i_s_tdata[2*VAL_W-1:VAL_W])),
        .i_beta     ($signed(i_s_tdata[3*VAL_W-1:2*VAL_W])),
        .i_mean     ($signed(i_s_tdata[4*VAL_W-1:3*VAL_W])),
        .i_variance (i_s_tdata[4*VAL_W+VAR_W-1:4*VAL_W]),
        .i_epsilon  (r_eps),
        .o_y        (dp_y),
        .o_sat      (dp_sat)
    );

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // A new result never overwrites one that is still waiting.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_go |-> (!r_out_valid || i_m_tready))
        else $error("result emitted over a pending result");

    // A data word with loaded parameters reaches its output step after the multiply and add steps.
    a_data_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (in_kind == KIND_DATA) && r_loaded) |-> ##5 (r_pc == S_D_OUT))
        else $error("data program length mismatch");

    // A header runs the full divide and square-root loops before finishing.
    a_hdr_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (in_kind == KIND_HDR)) |-> ##HDR_FIN_LAT (r_pc == S_H_FIN))
        else $error("header program length mismatch");

    // Each loop leaves with its counter exhausted.
    a_loop_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pc == S_H_SQI) || (r_pc == S_H_FIN)) |-> (r_cnt == '0))
        else $error("loop left with counter not exhausted");

endmodule

### sv/bnic_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnic_datapath: arithmetic datapath of the batch-norm channel
// Restoring divider, digit-by-digit square root and one shared signed
// multiplier, all driven by the operation code of the current control word.
// ----------------------------------------------------------------------------
module bnic_datapath (
    input  logic                                 i_clk,
    input  bnic_pkg::t_dp_ctrl                   i_ctrl,
    input  logic signed [bnic_pkg::VAL_W-1:0]    i_sample,
    input  logic signed [bnic_pkg::VAL_W-1:0]    i_gamma,
    input  logic signed [bnic_pkg::VAL_W-1:0]    i_beta,
    input  logic signed [bnic_pkg::VAL_W-1:0]    i_mean,
    input  logic        [bnic_pkg::VAR_W-1:0]    i_variance,
    input  logic        [bnic_pkg::EPS_W-1:0]    i_epsilon,
    output logic signed [bnic_pkg::VAL_W-1:0]    o_y,
    output logic                                 o_sat
);
    import bnic_pkg::*;

    logic        [V_W-1:0]     r_v,     n_v;
    logic        [V_W-1:0]     r_rem,   n_rem;
    logic        [LQ_W-1:0]    r_q,     n_q;
    logic        [INV_W-1:0]   r_inv,   n_inv;
    logic signed [T_W-1:0]     r_x,     n_x;
    logic signed [PROD_W-1:0]  r_prod,  n_prod;
    logic signed [ACC_W-1:0]   r_sum,   n_sum;
    logic signed [VAL_W-1:0]   r_mean,  n_mean;
    logic signed [VAL_W-1:0]   r_gamma, n_gamma;
    logic signed [VAL_W-1:0]   r_beta,  n_beta;

    logic        [V_W-1:0]     v_sum;
    logic        [V_W:0]       div_sh;
    logic        [V_W:0]       div_diff;
    logic                      div_ge;
    logic        [V_W-1:0]     sq_sh;
    logic        [V_W-1:0]     sq_trial;
    logic                      sq_ge;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [YW_W-1:0]    y_wide;

    // Offset variance; a zero sum is taken as one.
    assign v_sum = V_W'(i_variance) + V_W'(i_epsilon);

    // Divider: the dividend 2^48 shifts out of r_q while quotient bits shift in.
    assign div_sh   = {r_rem, r_q[DIV_STEPS-1]};
    assign div_ge   = (div_sh >= {1'b0, r_v});
    assign div_diff = div_sh - {1'b0, r_v};

    // Square root: two radicand bits per step, root accumulates in r_inv.
    assign sq_sh    = {r_rem[V_W-3:0], r_q[LQ_W-1:LQ_W-2]};
    assign sq_trial = V_W'({r_inv, 2'b01});
    assign sq_ge    = (sq_sh >= sq_trial);

    // Shared multiplier operand selection.
    always_comb begin
        unique case (i_ctrl.op)
            OP_MUL_D_INV: begin
                mul_a = MUL_A_W'($signed(r_x[D_W-1:0]));
                mul_b = $signed({1'b0, r_inv});
            end
            OP_MUL_T_LO: begin
                mul_a = MUL_A_W'(r_gamma);
                mul_b = $signed(MUL_B_W'(r_prod[FRAC_W+T_LO_W-1:FRAC_W]));
            end
            OP_MUL_T_HI: begin
                mul_a = MUL_A_W'(r_gamma);
                mul_b = MUL_B_W'($signed(r_x[T_W-1:T_LO_W]));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        n_v     = r_v;
        n_rem   = r_rem;
        n_q     = r_q;
        n_inv   = r_inv;
        n_x     = r_x;
        n_prod  = r_prod;
        n_sum   = r_sum;
        n_mean  = r_mean;
        n_gamma = r_gamma;
        n_beta  = r_beta;

        if (i_ctrl.hdr_load) begin
            n_v     = (v_sum == '0) ? V_W'(1) : v_sum;
            n_mean  = i_mean;
            n_gamma = i_gamma;
            n_beta  = i_beta;
        end
        if (i_ctrl.dat_load) begin
            n_x = T_W'(D_W'(i_sample) - D_W'(r_mean));
        end

        unique case (i_ctrl.op)
            OP_DIV_INIT: begin
                n_rem              = '0;
                n_q                = '0;
                n_q[DIV_STEPS-1]   = 1'b1;
            end
            OP_DIV_STEP: begin
                n_rem = div_ge ? div_diff[V_W-1:0] : div_sh[V_W-1:0];
                n_q   = {1'b0, r_q[DIV_STEPS-2:0], div_ge};
            end
            OP_SQRT_INIT: begin
                n_rem = '0;
                n_inv = '0;
            end
            OP_SQRT_STEP: begin
                n_rem = sq_ge ? (sq_sh - sq_trial) : sq_sh;
                n_inv = {r_inv[INV_W-2:0], sq_ge};
                n_q   = {r_q[LQ_W-3:0], 2'b00};
            end
            OP_MUL_D_INV: begin
                n_prod = mul_p;
            end
            OP_MUL_T_LO: begin
                // t = floor(d * inv / 2^16) is kept for its upper half.
                n_x    = r_prod[FRAC_W+T_W-1:FRAC_W];
                n_prod = mul_p;
            end
            OP_MUL_T_HI: begin
                n_sum  = ACC_W'(r_prod);
                n_prod = mul_p;
            end
            OP_ADD_HI: begin
                n_sum = r_sum + (ACC_W'(r_prod) <<< T_LO_W);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_v     <= n_v;
        r_rem   <= n_rem;
        r_q     <= n_q;
        r_inv   <= n_inv;
        r_x     <= n_x;
        r_prod  <= n_prod;
        r_sum   <= n_sum;
        r_mean  <= n_mean;
        r_gamma <= n_gamma;
        r_beta  <= n_beta;
    end

    // Final floor by 2^16, add beta and clamp to the 32-bit range.
    assign y_wide = YW_W'($signed(r_sum[ACC_W-1:FRAC_W])) + YW_W'(r_beta);
    assign o_sat  = (y_wide[YW_W-1:VAL_W-1] != {(YW_W-VAL_W+1){y_wide[VAL_W-1]}});

    always_comb begin
        if (!o_sat) begin
            o_y = y_wide[VAL_W-1:0];
        end else if (y_wide[YW_W-1]) begin
            o_y = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            o_y = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

endmodule
